@@ src/sli_pkg.sv @@
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants for the sorted list unit
// Action and status codes, the value width and the per-cell control and flag
// bundles passed between the top level and the storage cells.
// ----------------------------------------------------------------------------
package sli_pkg;

  // width of one stored value
  localparam int VAL_W = 32;

  // default list capacity
  localparam int DEF_LIST_DEPTH = 16;

  // request action codes
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic                    do_ins;
    logic                    do_rem;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

  // per-cell compare results
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flag_t;

endpackage

@@ src/sli_cell.sv @@
// ----------------------------------------------------------------------------
// sli_cell: one slot of the sorted list
// Holds one entry, compares it against the broadcast value and on insert or
// remove takes its left or right neighbor's entry to open or close a gap.
// ----------------------------------------------------------------------------
module sli_cell (
  input  logic                                 clk,
  input  sli_pkg::cell_ctrl_t                  ctrl,
  input  logic                                 occupied,
  input  logic                                 left_lt,
  input  logic signed [sli_pkg::VAL_W-1:0]     left_val,
  input  logic signed [sli_pkg::VAL_W-1:0]     right_val,
  output logic signed [sli_pkg::VAL_W-1:0]     entry,
  output sli_pkg::cell_flag_t                  flag
);
  import sli_pkg::*;

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;

  // compare against the broadcast value, only when the slot holds an entry
  always_comb begin
    flag.lt = occupied && (entry_r < ctrl.value);
    flag.eq = occupied && (entry_r == ctrl.value);
  end

  // slots at or above the insert point shift up, at or above the hit shift down
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.do_ins && !flag.lt) begin
      entry_nxt = left_lt ? ctrl.value : left_val;
    end else if (ctrl.do_rem && !flag.lt) begin
      entry_nxt = right_val;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

@@ src/sorted_list_insert_remove_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_unit: ascending list of signed values
// Insert, remove by value and find over a row of compare-and-shift cells with
// a count of stored entries and one registered result per request.
// ----------------------------------------------------------------------------
//  channel  ports                                        direction
//  in       in_valid in_stall in_action in_value         request in
//  out      out_valid out_stall out_status out_position  result out
//           out_value_out out_count
//
//  One request per cycle while the result is not stalled: every cell compares and shifts in the same cycle,
//  so the compare plus the first-hit encode across the row sets the cycle.
//  The result is registered and appears in the cycle after the request is taken.
//  Reset clears the count and the result valid; entries are left as they are.
//  A stalled result holds; a new request is taken whenever the result
//  register is empty or its result is taken in the same cycle.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_unit #(
  parameter int LIST_DEPTH = sli_pkg::DEF_LIST_DEPTH,
  parameter int POS_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic signed [sli_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [POS_W-1:0]                  out_position,
  output logic signed [sli_pkg::VAL_W-1:0]  out_value_out,
  output logic [CNT_W-1:0]                  out_count
);
  import sli_pkg::*;

  logic                     accept;
  action_t                  act;
  cell_ctrl_t               ctrl;
  logic signed [VAL_W-1:0]  entry_w [LIST_DEPTH];
  cell_flag_t               flag_w  [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]    left_lt_w;
  logic [LIST_DEPTH-1:0]    lt_vec;
  logic [LIST_DEPTH-1:0]    eq_vec;
  logic                     any_eq;
  logic                     full;
  logic                     empty;
  logic [POS_W-1:0]         ins_pos;
  logic [POS_W-1:0]         eq_pos;
  status_t                  st;
  logic [POS_W-1:0]         pos;

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     out_valid_r;
  status_t                  status_r;
  logic [POS_W-1:0]         position_r;
  logic signed [VAL_W-1:0]  value_r;

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign act      = action_t'(in_action);

  assign full  = (count_r == CNT_W'(LIST_DEPTH));
  assign empty = (count_r == '0);

  // row of cells
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] lv;
    logic signed [VAL_W-1:0] rv;
    if (g == 0) begin : g_first
      assign lv           = in_value;
      assign left_lt_w[g] = 1'b1;
    end else begin : g_mid
      assign lv           = entry_w[g-1];
      assign left_lt_w[g] = flag_w[g-1].lt;
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign rv = entry_w[g];
    end else begin : g_inner
      assign rv = entry_w[g+1];
    end
    assign lt_vec[g] = flag_w[g].lt;
    assign eq_vec[g] = flag_w[g].eq;

    sli_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (count_r > CNT_W'(g)),
      .left_lt   (left_lt_w[g]),
      .left_val  (lv),
      .right_val (rv),
      .entry     (entry_w[g]),
      .flag      (flag_w[g])
    );
  end

  assign any_eq = |eq_vec;

  // encode the insert point and the first equal slot
  always_comb begin
    ins_pos = '0;
    eq_pos  = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (!lt_vec[i] && left_lt_w[i]) begin
        ins_pos = ins_pos | POS_W'(i);
      end
      if (eq_vec[i] && ((i == 0) || !eq_vec[(i == 0) ? 0 : i - 1])) begin
        eq_pos = eq_pos | POS_W'(i);
      end
    end
  end

  // action decode, status and next count
  always_comb begin
    ctrl.do_ins = 1'b0;
    ctrl.do_rem = 1'b0;
    ctrl.value  = in_value;
    st          = ST_OK;
    pos         = '0;
    count_nxt   = count_r;
    case (act)
      ACT_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ctrl.do_ins = accept;
          pos         = ins_pos;
          count_nxt   = count_r + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (!any_eq) begin
          st = ST_MISSING;
        end else begin
          ctrl.do_rem = accept;
          pos         = eq_pos;
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      ACT_FIND: begin
        if (!any_eq) begin
          st = ST_MISSING;
        end else begin
          pos = eq_pos;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= st;
      position_r <= pos;
      value_r    <= in_value;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_position  = position_r;
  assign out_value_out = value_r;
  assign out_count     = count_r;

  // count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIST_DEPTH))
    else $error("entry count above capacity");

  // a successful insert grows the list by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (act == ACT_INSERT) && !full |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not bump the count");

  // a full report only comes with a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_FULL) |-> count_r == CNT_W'(LIST_DEPTH))
    else $error("full status with spare room");

  // errors always report position zero
  a_err_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_OK) |-> position_r == '0)
    else $error("nonzero position on error");

endmodule

@@ sim/sorted_list_insert_remove_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_unit_tb: self-checking bench for the sorted list
// Directed requests over empty, extreme and duplicate corners, then fill and
// drain sequences with random values under changing idle and stall rates.
// Each accepted request is scored against a local model of the list.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_unit_tb;
  import sli_pkg::*;

  localparam int DEPTH = DEF_LIST_DEPTH;
  localparam int POS_W = 4;
  localparam int CNT_W = 5;
  localparam int PHASE_ITEMS = 360;

  // sender idle and receiver stall percentages per phase
  localparam int SEND_IDLE [4] = '{0, 58, 0, 32};
  localparam int RECV_STALL[4] = '{0, 0, 58, 32};

  typedef struct {
    action_t                 act;
    logic signed [VAL_W-1:0] val;
    int                      send_idle;
    int                      recv_stall;
    bit                      hold_for_drain;
  } request_t;

  typedef struct {
    status_t                 status;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_action = ACT_NONE;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [1:0]              out_status;
  logic [POS_W-1:0]        out_position;
  logic signed [VAL_W-1:0] out_value_out;
  logic [CNT_W-1:0]        out_count;

  request_t                request_queue[$];
  list_result_t            due_results[$];
  logic signed [VAL_W-1:0] value_bag[$];
  logic signed [VAL_W-1:0] shelf[DEPTH];
  int                      shelf_len = 0;
  int                      recv_stall_pct = 0;
  int                      fail_count = 0;

  sorted_list_insert_remove_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_position  (out_position),
    .out_value_out (out_value_out),
    .out_count     (out_count)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // apply one request to the local list and return what the unit should report
  function automatic list_result_t predict_list_result(action_t act,
                                                       logic signed [VAL_W-1:0] v);
    list_result_t res;
    int           pos;
    res.status   = ST_OK;
    res.position = '0;
    res.value    = v;
    pos          = 0;
    case (act)
      ACT_INSERT: begin
        if (shelf_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          while (pos < shelf_len && shelf[pos] < v) pos++;
          for (int i = shelf_len; i > pos; i--) shelf[i] = shelf[i-1];
          shelf[pos] = v;
          shelf_len++;
          res.position = pos[POS_W-1:0];
        end
      end
      ACT_REMOVE, ACT_FIND: begin
        while (pos < shelf_len && shelf[pos] != v) pos++;
        if (act == ACT_REMOVE && shelf_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= shelf_len) begin
          res.status = ST_MISSING;
        end else begin
          res.position = pos[POS_W-1:0];
          if (act == ACT_REMOVE) begin
            for (int i = pos; i + 1 < shelf_len; i++) shelf[i] = shelf[i+1];
            shelf_len--;
          end
        end
      end
      default: ;
    endcase
    res.count = shelf_len[CNT_W-1:0];
    return res;
  endfunction

  // queue a request and track list contents for later value choice
  task automatic add_request(action_t act, logic signed [VAL_W-1:0] v, int ph,
                             bit hold);
    request_t r;
    int       hits[$];
    r.act            = act;
    r.val            = v;
    r.send_idle      = SEND_IDLE[ph];
    r.recv_stall     = RECV_STALL[ph];
    r.hold_for_drain = hold;
    request_queue.push_back(r);
    if (act == ACT_INSERT && value_bag.size() < DEPTH) begin
      value_bag.push_back(v);
    end else if (act == ACT_REMOVE) begin
      hits = value_bag.find_first_index(x) with (x == v);
      if (hits.size() > 0) value_bag.delete(hits[0]);
    end
  endtask

  // small values for duplicates, some extremes, mostly full range
  function automatic logic signed [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return int'($urandom_range(8)) - 4;
    if (roll < 40) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // driver: present queued requests, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(predict_list_result(action_t'(in_action), in_value));
      end
      if (!in_valid || !in_stall) begin
        if (request_queue.size() > 0
            && !(request_queue[0].hold_for_drain && due_results.size() > 0)
            && $urandom_range(99) >= request_queue[0].send_idle) begin
          in_action      <= request_queue[0].act;
          in_value       <= request_queue[0].val;
          recv_stall_pct <= request_queue[0].recv_stall;
          in_valid       <= 1'b1;
          void'(request_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: score each taken result, stall at random
  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result with no request pending: status %0d position %0d",
                 out_status, out_position);
          fail_count++;
        end else begin
          exp_res = due_results.pop_front();
          if (out_status !== exp_res.status) begin
            $error("status: expected %0d actual %0d", exp_res.status, out_status);
            fail_count++;
          end
          if (out_position !== exp_res.position) begin
            $error("position: expected %0d actual %0d", exp_res.position, out_position);
            fail_count++;
          end
          if (out_value_out !== exp_res.value) begin
            $error("value_out: expected %0d actual %0d", exp_res.value, out_value_out);
            fail_count++;
          end
          if (out_count !== exp_res.count) begin
            $error("count: expected %0d actual %0d", exp_res.count, out_count);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // stimulus, reset and end of run
  initial begin
    bit                      filling;
    int                      roll;
    action_t                 act;
    logic signed [VAL_W-1:0] v;

    // directed corners: empty list, ignored action, extremes, duplicates
    add_request(ACT_FIND,   32'sd0,           0, 1'b0);
    add_request(ACT_REMOVE, 32'sd5,           0, 1'b0);
    add_request(ACT_NONE,   32'sh8000_0000,   0, 1'b0);
    add_request(ACT_INSERT, 32'sd0,           0, 1'b0);
    add_request(ACT_INSERT, 32'sh7fff_ffff,   0, 1'b0);
    add_request(ACT_INSERT, 32'sh8000_0000,   0, 1'b0);
    add_request(ACT_INSERT, -32'sd1,          0, 1'b0);
    add_request(ACT_INSERT, 32'sd0,           0, 1'b0);
    add_request(ACT_INSERT, 32'sd1,           0, 1'b0);
    add_request(ACT_FIND,   32'sd0,           0, 1'b0);
    add_request(ACT_FIND,   32'sd7,           0, 1'b0);
    add_request(ACT_REMOVE, 32'sd7,           0, 1'b0);
    add_request(ACT_REMOVE, 32'sh8000_0000,   0, 1'b0);
    add_request(ACT_REMOVE, 32'sh7fff_ffff,   0, 1'b0);
    add_request(ACT_REMOVE, 32'sd0,           0, 1'b0);
    add_request(ACT_NONE,   32'sh5a5a_a5a5,   0, 1'b0);
    add_request(ACT_REMOVE, 32'sd0,           0, 1'b0);
    add_request(ACT_REMOVE, -32'sd1,          0, 1'b0);
    add_request(ACT_REMOVE, 32'sd1,           0, 1'b0);

    // fill and drain sequences, one block per idle and stall phase
    filling = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 3)                act = ACT_NONE;
        else if (filling)            act = (roll < 68) ? ACT_INSERT :
                                           (roll < 84) ? ACT_FIND : ACT_REMOVE;
        else                         act = (roll < 60) ? ACT_REMOVE :
                                           (roll < 80) ? ACT_FIND : ACT_INSERT;
        if (act != ACT_INSERT && value_bag.size() > 0 && $urandom_range(99) < 70)
          v = value_bag[$urandom_range(value_bag.size() - 1)];
        else
          v = pick_value();
        add_request(act, v, ph, (n == 0 && ph > 0));
        // stay full or empty for a few requests before turning around
        if (value_bag.size() == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
        if (value_bag.size() == 0 && $urandom_range(2) == 0) filling = 1'b1;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() > 0 || in_valid || due_results.size() > 0)
      @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sorted_list_insert_remove_unit.f @@
src/sli_pkg.sv
src/sli_cell.sv
src/sorted_list_insert_remove_unit.sv
sim/sorted_list_insert_remove_unit_tb.sv
